>>> src/lbao_pkg.sv
// Shared types and codes for the linked block allocator.
// No dependencies; imported by every module of the block.
package lbao_pkg;

    // Request function codes
    localparam logic FUNC_CREATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_BLOCK = 2'd1;
    localparam logic [1:0] STAT_ZERO_LEN  = 2'd2;
    localparam logic [1:0] STAT_NO_SPACE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_SCAN,
        S_DONE
    } lbao_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic commit_start;
        logic set_create;
        logic capture_read;
        logic scan_step;
        logic out_load;
    } lbao_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_read;
        logic create_ok;
        logic need_one;
        logic scan_done;
        logic out_free;
    } lbao_stat_t;

endpackage

>>> src/lbao_ctrl.sv
// Sequencing controller for the linked block allocator.
// Depends on lbao_pkg for the state, command and status types.
module lbao_ctrl
    import lbao_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  lbao_stat_t st,
    output lbao_cmd_t  cmd
);

    lbao_state_t state_reg;
    lbao_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.is_read)
                begin
                    state_next = S_READ;
                end
                else if (st.create_ok && !st.need_one)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_EVAL:
            begin
                cmd.set_create   = !st.is_read;
                cmd.commit_start = !st.is_read && st.create_ok;
            end
            S_READ:
            begin
                cmd.capture_read = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = st.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> src/lbao_dp.sv
// Datapath of the linked block allocator: block marks, link and owner stores,
// request and result registers. Depends on lbao_pkg.
module lbao_dp
    import lbao_pkg::*;
#(
    parameter int NUM_BLOCKS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        func,
    input  logic [5:0]  block_index,
    input  logic [15:0] owner_id,
    input  logic [5:0]  length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  free_count,
    output logic        entry_free,
    output logic        entry_end,
    output logic [4:0]  entry_next,
    output logic [15:0] entry_owner,
    input  lbao_cmd_t   cmd,
    output lbao_stat_t  st
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Request registers
    logic        req_func_reg;
    logic [5:0]  req_index_reg;
    logic [15:0] req_owner_reg;
    logic [5:0]  req_length_reg;

    // Block marks and free count
    logic [NUM_BLOCKS-1:0] free_reg;
    logic [NUM_BLOCKS-1:0] end_reg;
    logic [5:0]            free_total_reg;

    // Scan state
    logic [IW-1:0] scan_reg;
    logic [IW-1:0] prev_reg;
    logic [5:0]    need_reg;

    // Stores
    logic [IW-1:0] next_mem  [NUM_BLOCKS];
    logic [15:0]   owner_mem [NUM_BLOCKS];
    logic [IW-1:0] next_rd_reg;
    logic [15:0]   owner_rd_reg;

    // Pending result
    logic [1:0]  res_status_reg;
    logic        res_free_reg;
    logic        res_end_reg;
    logic [4:0]  res_next_reg;
    logic [15:0] res_owner_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [5:0]  out_free_count_reg;
    logic        out_free_reg;
    logic        out_end_reg;
    logic [4:0]  out_next_reg;
    logic [15:0] out_owner_reg;

    logic          in_range;
    logic [IW-1:0] idx;
    logic [1:0]    chk_status;
    logic          scan_hit;
    logic          owner_we;
    logic [IW-1:0] owner_wa;

    assign in_range = req_index_reg < 6'(NUM_BLOCKS);
    assign idx      = req_index_reg[IW-1:0];
    assign scan_hit = free_reg[scan_reg];

    always_comb
    begin
        if (!in_range || !free_reg[idx])
        begin
            chk_status = STAT_BAD_BLOCK;
        end
        else if (req_length_reg == 6'd0)
        begin
            chk_status = STAT_ZERO_LEN;
        end
        else if (req_length_reg > free_total_reg)
        begin
            chk_status = STAT_NO_SPACE;
        end
        else
        begin
            chk_status = STAT_OK;
        end
    end

    always_comb
    begin
        st.is_read   = (req_func_reg == FUNC_READ);
        st.create_ok = (chk_status == STAT_OK);
        st.need_one  = (req_length_reg == 6'd1);
        st.scan_done = (scan_hit && need_reg == 6'd1) || (scan_reg == IW'(NUM_BLOCKS - 1));
        st.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_func_reg   <= func;
            req_index_reg  <= block_index;
            req_owner_reg  <= owner_id;
            req_length_reg <= length;
        end
    end

    // Marks and free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg       <= '1;
            end_reg        <= '0;
            free_total_reg <= 6'(NUM_BLOCKS);
        end
        else
        begin
            if (cmd.commit_start)
            begin
                free_reg[idx]  <= 1'b0;
                end_reg[idx]   <= 1'b1;
                free_total_reg <= free_total_reg - req_length_reg;
            end
            if (cmd.scan_step && scan_hit)
            begin
                end_reg[prev_reg]  <= 1'b0;
                free_reg[scan_reg] <= 1'b0;
                end_reg[scan_reg]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_start)
        begin
            scan_reg <= '0;
            prev_reg <= idx;
            need_reg <= req_length_reg - 6'd1;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (scan_hit)
            begin
                prev_reg <= scan_reg;
                need_reg <= need_reg - 6'd1;
            end
        end
    end

    // One write port per store
    assign owner_we = cmd.commit_start || (cmd.scan_step && scan_hit);
    assign owner_wa = cmd.commit_start ? idx : scan_reg;

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[owner_wa] <= req_owner_reg;
        end
        if (cmd.scan_step && scan_hit)
        begin
            next_mem[prev_reg] <= scan_reg;
        end
        owner_rd_reg <= owner_mem[idx];
        next_rd_reg  <= next_mem[idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_create)
        begin
            res_status_reg <= chk_status;
            res_free_reg   <= 1'b0;
            res_end_reg    <= 1'b0;
            res_next_reg   <= '0;
            res_owner_reg  <= '0;
        end
        else if (cmd.capture_read)
        begin
            if (!in_range)
            begin
                res_status_reg <= STAT_BAD_BLOCK;
                res_free_reg   <= 1'b0;
                res_end_reg    <= 1'b0;
                res_next_reg   <= '0;
                res_owner_reg  <= '0;
            end
            else
            begin
                res_status_reg <= STAT_OK;
                res_free_reg   <= free_reg[idx];
                res_end_reg    <= end_reg[idx];
                res_next_reg   <= (!free_reg[idx] && !end_reg[idx]) ? 5'(next_rd_reg) : 5'd0;
                res_owner_reg  <= free_reg[idx] ? 16'd0 : owner_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg     <= res_status_reg;
            out_free_count_reg <= free_total_reg;
            out_free_reg       <= res_free_reg;
            out_end_reg        <= res_end_reg;
            out_next_reg       <= res_next_reg;
            out_owner_reg      <= res_owner_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign free_count  = out_free_count_reg;
    assign entry_free  = out_free_reg;
    assign entry_end   = out_end_reg;
    assign entry_next  = out_next_reg;
    assign entry_owner = out_owner_reg;

endmodule

>>> src/linked_block_allocator_with_owner.sv
// Linked block allocator: one transaction at a time. A read passes through the evaluate
// and read states to its result; a create goes from evaluate straight to the result
// when rejected or of one block, else through the one-block-per-cycle link scan.
// The next transaction is taken the cycle after the result enters the output register.
// rst_n (async, active low) frees every block and clears end marks; link and owner
// stores are not cleared, their stale contents are masked by the free and end marks.
module linked_block_allocator_with_owner
    import lbao_pkg::*;
#(
    parameter int NUM_BLOCKS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [5:0]  block_index,
    input  logic [15:0] owner_id,
    input  logic [5:0]  length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  free_count,
    output logic        entry_free,
    output logic        entry_end,
    output logic [4:0]  entry_next,
    output logic [15:0] entry_owner
);

    // Command and status links between controller and datapath
    lbao_cmd_t  cmd;
    lbao_stat_t st;

    // Controller: accept, evaluate, scan or read, then hand the result on
    lbao_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: hold the request, the block marks, the stores and the result
    lbao_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .block_index (block_index),
        .owner_id    (owner_id),
        .length      (length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .free_count  (free_count),
        .entry_free  (entry_free),
        .entry_end   (entry_end),
        .entry_next  (entry_next),
        .entry_owner (entry_owner),
        .cmd         (cmd),
        .st          (st)
    );

`ifndef SYNTHESIS
    // Hold off further transactions once one has been taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in progress");

    // The free count can never grow beyond the store size
    a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_count <= 6'(NUM_BLOCKS)))
        else $error("free count above store size");

    // A rejected request returns no entry data
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |->
        (!entry_free && !entry_end && entry_next == 5'd0 && entry_owner == 16'd0))
        else $error("entry data on rejected request");
`endif

endmodule

>>> verif/lbao_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the linked block allocator: watches both channels, keeps its own
// copy of the block store and compares every result. Depends on lbao_pkg.
module lbao_result_checker
    import lbao_pkg::*;
#(
    parameter int BLOCKS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        func,
    input  logic [5:0]  block_index,
    input  logic [15:0] owner_id,
    input  logic [5:0]  length,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [5:0]  free_count,
    input  logic        entry_free,
    input  logic        entry_end,
    input  logic [4:0]  entry_next,
    input  logic [15:0] entry_owner,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  free_count;
        logic        entry_free;
        logic        entry_end;
        logic [4:0]  entry_next;
        logic [15:0] entry_owner;
    } block_result_t;

    // Shadow of the block store
    logic        free_mark [BLOCKS];
    logic        end_mark  [BLOCKS];
    logic [4:0]  link      [BLOCKS];
    logic [15:0] owner_of  [BLOCKS];
    logic [5:0]  free_left;

    block_result_t awaited_results[$];

    initial errors = 0;
    assign pending = awaited_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Apply one request to the shadow store and return the result it must produce.
    function automatic block_result_t allocate_or_read(input logic f, input logic [5:0] idx,
                                                       input logic [15:0] who,
                                                       input logic [5:0] len);
        block_result_t r;
        logic [4:0]    prev;
        logic [5:0]    need;
        r = '0;
        if (f == FUNC_CREATE)
        begin
            if (idx >= BLOCKS || !free_mark[idx[4:0]])
                r.status = STAT_BAD_BLOCK;
            else if (len == 6'd0)
                r.status = STAT_ZERO_LEN;
            else if (len > free_left)
                r.status = STAT_NO_SPACE;
            else
            begin
                r.status = STAT_OK;
                free_mark[idx[4:0]] = 1'b0;
                owner_of[idx[4:0]]  = who;
                end_mark[idx[4:0]]  = 1'b1;
                prev = idx[4:0];
                need = len - 6'd1;
                // Link further free blocks in ascending order, skipping the start
                for (int b = 0; b < BLOCKS; b++)
                begin
                    if (need != 6'd0 && free_mark[b] && b != idx)
                    begin
                        link[prev]     = b[4:0];
                        end_mark[prev] = 1'b0;
                        free_mark[b]   = 1'b0;
                        owner_of[b]    = who;
                        end_mark[b]    = 1'b1;
                        prev           = b[4:0];
                        need--;
                    end
                end
                free_left = free_left - len;
            end
        end
        else if (idx >= BLOCKS)
        begin
            r.status = STAT_BAD_BLOCK;
        end
        else
        begin
            r.status      = STAT_OK;
            r.entry_free  = free_mark[idx[4:0]];
            r.entry_end   = end_mark[idx[4:0]];
            r.entry_owner = owner_of[idx[4:0]];
            if (!free_mark[idx[4:0]] && !end_mark[idx[4:0]])
                r.entry_next = link[idx[4:0]];
        end
        r.free_count = free_left;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        block_result_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < BLOCKS; b++)
            begin
                free_mark[b] = 1'b1;
                end_mark[b]  = 1'b0;
                link[b]      = '0;
                owner_of[b]  = '0;
            end
            free_left = BLOCKS[5:0];
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected result, status", 32'(status), '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (free_count !== want.free_count)
                        report_mismatch("free_count", 32'(free_count),
                                        32'(want.free_count));
                    if (entry_free !== want.entry_free)
                        report_mismatch("entry_free", 32'(entry_free),
                                        32'(want.entry_free));
                    if (entry_end !== want.entry_end)
                        report_mismatch("entry_end", 32'(entry_end), 32'(want.entry_end));
                    if (entry_next !== want.entry_next)
                        report_mismatch("entry_next", 32'(entry_next),
                                        32'(want.entry_next));
                    if (entry_owner !== want.entry_owner)
                        report_mismatch("entry_owner", 32'(entry_owner),
                                        32'(want.entry_owner));
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(allocate_or_read(func, block_index, owner_id,
                                                           length));
        end
    end

endmodule

>>> verif/tb_linked_block_allocator_with_owner.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus and the verdict.
// Depends on lbao_pkg, the allocator and lbao_result_checker.
module tb_linked_block_allocator_with_owner;
    import lbao_pkg::*;

    localparam int RANDOM_ITEMS = 1330;
    localparam int QUIET_TAIL   = 150;   // last requests go out with no idling
    localparam int IDLE_LIMIT   = 3000;  // cycles with no transaction before giving up
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int HOLD_AFTER   = 200;   // results seen before the hold-off starts

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [5:0]  block_index;
    logic [15:0] owner_id;
    logic [5:0]  length;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [5:0]  free_count;
    logic        entry_free;
    logic        entry_end;
    logic [4:0]  entry_next;
    logic [15:0] entry_owner;

    int errors;
    int pending;
    int results_seen;
    int idle_cycles;
    bit quiet;

    linked_block_allocator_with_owner u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .block_index (block_index),
        .owner_id    (owner_id),
        .length      (length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .free_count  (free_count),
        .entry_free  (entry_free),
        .entry_end   (entry_end),
        .entry_next  (entry_next),
        .entry_owner (entry_owner)
    );

    lbao_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .block_index (block_index),
        .owner_id    (owner_id),
        .length      (length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .free_count  (free_count),
        .entry_free  (entry_free),
        .entry_end   (entry_end),
        .entry_next  (entry_next),
        .entry_owner (entry_owner),
        .errors      (errors),
        .pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive every input to a known value from time zero
    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_CREATE;
        block_index = '0;
        owner_id    = '0;
        length      = '0;
        out_stall   = 1'b0;
        quiet       = 1'b0;
    end

    // Count result transactions so the receiver knows when to start its long hold-off
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            results_seen++;

    // Watchdog: end the run if no transaction moves on either channel for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAIL linked_block_allocator_with_owner");
                $finish;
            end
        end
    end

    // Receiver: stall in random bursts, once hold off for a long stretch so the block
    // fills and backs up its input, and stop stalling altogether in the quiet tail.
    initial begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                stall_left = HOLD_CYCLES;
                hold_done  = 1'b1;
            end
            if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else
                out_stall = 1'b0;
        end
    end

    // Offer one request and hold it until the block takes it. Now and then drop valid
    // for a burst first, so gaps land on every phase of the block's work.
    task automatic issue(input logic f, input logic [5:0] idx, input logic [15:0] who,
                         input logic [5:0] len);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    = 1'b1;
        func        = f;
        block_index = idx;
        owner_id    = who;
        length      = len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial begin
        logic        f;
        logic [5:0]  idx;
        logic [5:0]  len;
        int          drain;

        // Hold reset from time zero, then release it on a falling edge, away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: every status, both functions, field extremes
        issue(FUNC_READ,   6'd0,  16'h0000, 6'd0);   // free block, never written
        issue(FUNC_READ,   6'd63, 16'hFFFF, 6'd63);  // read far out of range
        issue(FUNC_READ,   6'd32, 16'h0000, 6'd0);   // read just out of range
        issue(FUNC_CREATE, 6'd40, 16'h1234, 6'd1);   // start out of range
        issue(FUNC_CREATE, 6'd5,  16'h5555, 6'd0);   // zero length
        issue(FUNC_CREATE, 6'd5,  16'hAAAA, 6'd63);  // far too long
        issue(FUNC_CREATE, 6'd5,  16'hAAAA, 6'd33);  // one more than the store holds
        issue(FUNC_CREATE, 6'd31, 16'hFFFF, 6'd1);   // single-block chain at the top
        issue(FUNC_CREATE, 6'd31, 16'h0001, 6'd1);   // start already in use
        issue(FUNC_CREATE, 6'd3,  16'h0000, 6'd3);   // chain skips its start: 3, 0, 1
        issue(FUNC_READ,   6'd3,  16'h0000, 6'd0);
        issue(FUNC_READ,   6'd0,  16'h0000, 6'd0);
        issue(FUNC_READ,   6'd1,  16'h0000, 6'd0);
        issue(FUNC_READ,   6'd2,  16'h0000, 6'd0);
        issue(FUNC_READ,   6'd31, 16'h0000, 6'd0);
        issue(FUNC_CREATE, 6'd0,  16'h7777, 6'd2);   // start taken by an earlier chain
        issue(FUNC_CREATE, 6'd10, 16'h8001, 6'd30);  // more than the free blocks left
        issue(FUNC_CREATE, 6'd10, 16'h8001, 6'd4);   // ordinary chain from the middle

        // Random part: mostly short chains so the store fills gradually and many
        // creates succeed before every start block is in use.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            f = $urandom_range(0, 1) ? FUNC_READ : FUNC_CREATE;
            idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(32, 63))
                                              : 6'($urandom_range(0, 31));
            case ($urandom_range(0, 9))
                0:       len = 6'd0;
                1:       len = 6'($urandom_range(4, 63));
                default: len = 6'($urandom_range(1, 3));
            endcase
            issue(f, idx, 16'($urandom), len);
        end

        @(negedge clk);
        in_valid = 1'b0;

        // Drain: wait for every awaited result, then keep the clock running to catch stray ones
        drain = 0;
        while (pending != 0 && drain < IDLE_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (50) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("PASS linked_block_allocator_with_owner");
        else
            $display("FAIL linked_block_allocator_with_owner");
        $finish;
    end

endmodule

>>> files.f
src/lbao_pkg.sv
src/lbao_ctrl.sv
src/lbao_dp.sv
src/linked_block_allocator_with_owner.sv
verif/lbao_result_checker.sv
verif/tb_linked_block_allocator_with_owner.sv
